// File: design/idq_pkg.sv
package idq_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [2:0] ACT_SET        = 3'd0;
  localparam logic [2:0] ACT_GET        = 3'd1;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd3;
  localparam logic [2:0] ACT_POP_BACK   = 3'd4;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  position;
    logic [63:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] word_out;
    logic [6:0]  length;
    logic [1:0]  status;
  } out_item_t;

endpackage

// File: design/idq_store.sv
module idq_store
  import idq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  output logic          clr_busy
);

  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  logic [63:0]   mem [CAPACITY];
  logic [63:0]   rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [63:0]   wd;

  assign we = clr_busy_r || wr_en;
  assign wa = clr_busy_r ? clr_idx_r : wr_addr;
  assign wd = clr_busy_r ? 64'd0 : wr_data;

  // sweep zeros through the store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: design/indexed_deque_store_top.sv
// Double-ended array of 64-bit words in a ring store of CAPACITY slots.
// Input channel (in_valid/in_ready/in_data) carries one operation per item:
// set or get at an index, push or pop at either end. Result channel
// (out_valid/out_ready/out_data) returns one item per operation with the
// word read or popped, the element count after the operation and a status.
// Output: a result is registered and valid in the cycle after its operation is accepted.
// Throughput: one operation per cycle when not stalled; one write port and
// one registered read port, each operation using at most one of each.
// Reset: rst_n is synchronous, active low. It empties the array and then
// runs a clearing pass that zeroes every slot; in_ready stays low during
// that pass.
// Stall: a result waits in the output register while out_ready is low; one
// new operation is accepted in the cycle the waiting result is taken, and
// none while the output register holds an untaken result.
module indexed_deque_store_top
  import idq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [AW:0]   CAP_W    = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X    = XW'(CAPACITY);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic          rsel_r, rsel_nxt;
  logic [6:0]    len_r;
  logic [1:0]    status_r, status_nxt;

  logic          acc;
  logic          clr_busy;
  logic          wr_en, rd_en, do_wr, do_rd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_data, rd_data;
  logic [XW-1:0] pos_x, cnt_x;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready = !clr_busy && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign pos_x    = XW'(in_data.position);
  assign cnt_x    = XW'(count_r);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rsel_nxt   = 1'b0;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    wr_addr    = head_r;
    rd_addr    = head_r;
    wr_data    = in_data.word_in;
    unique case (in_data.action)
      ACT_SET: begin
        if (pos_x >= CAP_X) begin
          status_nxt = ST_FULL;
        end else begin
          do_wr   = 1'b1;
          wr_addr = ring(head_r, AW'(in_data.position));
          if (pos_x >= cnt_x) begin
            count_nxt = CW'(pos_x + XW'(1));
          end
        end
      end
      ACT_GET: begin
        if (pos_x < cnt_x) begin
          do_rd    = 1'b1;
          rsel_nxt = 1'b1;
          rd_addr  = ring(head_r, AW'(in_data.position));
        end
      end
      ACT_PUSH_BACK: begin
        if (count_r == CAP_C) begin
          status_nxt = ST_FULL;
        end else begin
          do_wr     = 1'b1;
          wr_addr   = ring(head_r, AW'(count_r));
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (count_r == CAP_C) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
          do_wr     = 1'b1;
          wr_addr   = head_nxt;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_rd     = 1'b1;
          do_wr     = 1'b1;
          rsel_nxt  = 1'b1;
          rd_addr   = ring(head_r, AW'(count_r - CW'(1)));
          wr_addr   = rd_addr;
          wr_data   = 64'd0;
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_rd     = 1'b1;
          do_wr     = 1'b1;
          rsel_nxt  = 1'b1;
          rd_addr   = head_r;
          wr_addr   = head_r;
          wr_data   = 64'd0;
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en = acc && do_wr;
  assign rd_en = acc && do_rd;

  idq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsel_r   <= rsel_nxt;
      len_r    <= 7'(count_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data.word_out = rsel_r ? rd_data : 64'd0;
  assign out_data.length   = len_r;
  assign out_data.status   = status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && do_rd && do_wr |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not shrink the array");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> len_r == 7'd0 && !rsel_r)
    else $error("empty status with nonzero length");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(rd_data) && $stable(len_r))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/indexed_deque_store_top_test.sv
`timescale 1ns / 100ps

import idq_pkg::*;

class deque_scoreboard;
  localparam int CAP = CAPACITY_DEF;

  logic [63:0] slots [CAP];
  int          head;
  int          count;
  out_item_t   pending_q [$];
  int          errors;

  function new();
    foreach (slots[i]) slots[i] = '0;
    head   = 0;
    count  = 0;
    errors = 0;
  endfunction

  function void note_input(in_item_t op);
    out_item_t e;
    int        pos;
    int        p;
    e   = '0;
    pos = int'(op.position);
    e.status = ST_OK;
    case (op.action)
      ACT_SET: begin
        if (pos >= CAP) begin
          e.status = ST_FULL;
        end else begin
          slots[(head + pos) % CAP] = op.word_in;
          if (pos >= count) count = pos + 1;
        end
      end
      ACT_GET: begin
        if (pos < count) e.word_out = slots[(head + pos) % CAP];
      end
      ACT_PUSH_BACK: begin
        if (count >= CAP) begin
          e.status = ST_FULL;
        end else begin
          slots[(head + count) % CAP] = op.word_in;
          count++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (count >= CAP) begin
          e.status = ST_FULL;
        end else begin
          head = (head + CAP - 1) % CAP;
          slots[head] = op.word_in;
          count++;
        end
      end
      ACT_POP_BACK: begin
        if (count == 0) begin
          e.status = ST_EMPTY;
        end else begin
          p = (head + count - 1) % CAP;
          e.word_out = slots[p];
          slots[p] = '0;
          count--;
        end
      end
      ACT_POP_FRONT: begin
        if (count == 0) begin
          e.status = ST_EMPTY;
        end else begin
          e.word_out = slots[head];
          slots[head] = '0;
          head = (head + 1) % CAP;
          count--;
        end
      end
      default: begin
      end
    endcase
    e.length = 7'(count);
    pending_q.push_back(e);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp;
    if (pending_q.size() == 0) begin
      $error("unexpected result: word_out %h length %0d status %0d",
             got.word_out, got.length, got.status);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (got.word_out !== exp.word_out) begin
      $error("word_out mismatch: expected %h, actual %h", exp.word_out, got.word_out);
      errors++;
    end
    if (got.length !== exp.length) begin
      $error("length mismatch: expected %0d, actual %0d", exp.length, got.length);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module indexed_deque_store_top_test;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS = 1200;
  localparam int IDLE_LIMIT = 4000;

  localparam int MODE_FILL     = 0;
  localparam int MODE_DRAIN    = 1;
  localparam int MODE_BALANCED = 2;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  deque_scoreboard sb;
  bit              no_idle;
  int              idle_cycles;

  indexed_deque_store_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic in_item_t make_op(logic [2:0] action, logic [5:0] position,
                                       logic [63:0] word);
    in_item_t op;
    op.action   = action;
    op.position = position;
    op.word_in  = word;
    return op;
  endfunction

  function automatic in_item_t next_random_op(int mode);
    in_item_t op;
    int       cut [7];
    int       r;
    int       k;
    int       w;
    case (mode)
      MODE_FILL:  cut = '{15, 30, 60, 90, 94, 98, 100};
      MODE_DRAIN: cut = '{5, 20, 25, 30, 63, 98, 100};
      default:    cut = '{15, 35, 50, 65, 80, 98, 100};
    endcase
    r = $urandom_range(0, 99);
    k = 0;
    while (r >= cut[k]) k++;
    if (k < 6) begin
      op.action = 3'(k);
    end else begin
      op.action = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
    end
    op.position = 6'($urandom_range(0, 63));
    if (sb.count > 0 && $urandom_range(0, 1)) begin
      if (op.action == ACT_GET) begin
        op.position = 6'($urandom_range(0, sb.count - 1));
      end else if (op.action == ACT_SET) begin
        op.position = 6'($urandom_range(0, (sb.count < 63) ? sb.count : 63));
      end
    end
    w = $urandom_range(0, 15);
    if (w == 0) begin
      op.word_in = '0;
    end else if (w == 1) begin
      op.word_in = '1;
    end else begin
      op.word_in = {$urandom, $urandom};
    end
    return op;
  endfunction

  task automatic send_op(input in_item_t op);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_input(op);
  endtask

  initial begin
    int span;
    int mode;
    sb       = new();
    no_idle  = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_op(make_op(ACT_GET, 6'd0, 64'h1));
    send_op(make_op(ACT_POP_BACK, 6'd0, '0));
    send_op(make_op(ACT_POP_FRONT, 6'd63, '1));
    send_op(make_op(ACT_SET, 6'd63, '1));
    send_op(make_op(ACT_GET, 6'd0, '0));
    send_op(make_op(ACT_GET, 6'd63, '0));
    send_op(make_op(ACT_PUSH_BACK, 6'd0, 64'hDEAD_BEEF_DEAD_BEEF));
    send_op(make_op(ACT_PUSH_FRONT, 6'd0, 64'hDEAD_BEEF_DEAD_BEEF));
    send_op(make_op(ACT_SET, 6'd0, 64'h0123_4567_89AB_CDEF));
    send_op(make_op(ACT_GET, 6'd0, '0));
    send_op(make_op(ACT_SPARE_6, 6'd5, '1));
    send_op(make_op(ACT_SPARE_7, 6'd63, '1));
    send_op(make_op(ACT_POP_BACK, 6'd0, '0));
    send_op(make_op(ACT_POP_FRONT, 6'd0, '0));
    send_op(make_op(ACT_PUSH_FRONT, 6'd0, 64'hA5A5_A5A5_5A5A_5A5A));
    send_op(make_op(ACT_PUSH_FRONT, 6'd0, 64'h8000_0000_0000_0001));
    send_op(make_op(ACT_PUSH_BACK, 6'd0, 64'h7FFF_FFFF_FFFF_FFFE));
    send_op(make_op(ACT_GET, 6'd63, '0));
    send_op(make_op(ACT_GET, 6'd0, '0));
    send_op(make_op(ACT_POP_FRONT, 6'd0, '0));
    send_op(make_op(ACT_POP_BACK, 6'd0, '0));
    send_op(make_op(ACT_GET, 6'd63, '0));
    send_op(make_op(ACT_SET, 6'd62, '0));

    mode = MODE_DRAIN;
    span = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (span == 0) begin
        mode = $urandom_range(MODE_FILL, MODE_BALANCED);
        span = $urandom_range(60, 150);
      end
      span--;
      no_idle = ((n / 80) % 5 == 4);
      send_op(next_random_op(mode));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule
